// File: src/rtoe_pkg.sv
// ----------------------------------------------------------------------------
// rtoe_pkg
// Shared types and constants for the retransmission timeout estimator and
// congestion window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rtoe_pkg;

	// bit-serial units step one bit per cycle over 16-bit operands
	localparam int unsigned SER_STEPS = 16;
	localparam int unsigned SER_CNT_W = $clog2(SER_STEPS);

	// additive increase adds segment_size / 16 on top of the quotient
	localparam int unsigned MSS_SHIFT = 4;

	localparam logic [15:0] TIMEOUT_RESET = 16'd200;

	localparam logic [12:0] FLUSH_INTERVAL_RESET       = 13'd100;
	localparam logic [15:0] MIN_TIMEOUT_RESET          = 16'd100;
	localparam logic [15:0] MAX_TIMEOUT_RESET          = 16'd60000;
	localparam logic [15:0] SEGMENT_SIZE_RESET         = 16'd1376;
	localparam logic [15:0] SLOW_START_THRESHOLD_RESET = 16'd2;

	typedef enum logic [2:0] {
		REG_FLUSH_INTERVAL       = 3'd0,
		REG_MIN_TIMEOUT          = 3'd1,
		REG_MAX_TIMEOUT          = 3'd2,
		REG_SEGMENT_SIZE         = 3'd3,
		REG_SLOW_START_THRESHOLD = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_RUN,
		TOP_PUSH
	} top_state_t;

	typedef enum logic [3:0] {
		RT_IDLE,
		RT_STEP1,
		RT_STEP2,
		RT_STEP3,
		RT_STEP4,
		RT_TMO1,
		RT_TMO2,
		RT_TMO3,
		RT_TMO4,
		RT_DONE
	} rtt_state_t;

	typedef enum logic [2:0] {
		CW_IDLE,
		CW_DECIDE,
		CW_MUL,
		CW_DIV,
		CW_SUM,
		CW_CMP,
		CW_DONE
	} cw_state_t;

endpackage

`default_nettype wire

// File: src/rtoe_ser_mul.sv
// ----------------------------------------------------------------------------
// rtoe_ser_mul
// Bit-serial dual multiplier: one multiplier bit per cycle, msb first,
// forming a * m and b * m with a shared 16-bit multiplier shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoe_ser_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] a,
	input  wire logic [15:0] b,
	input  wire logic [15:0] mpl,
	output logic      [31:0] prod_a,
	output logic      [31:0] prod_b,
	output logic             done
);
	import rtoe_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [SER_CNT_W-1:0] cnt_q;
	logic [15:0]          a_q;
	logic [15:0]          b_q;
	logic [15:0]          mpl_q;
	logic [31:0]          acc_a_q;
	logic [31:0]          acc_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= SER_CNT_W'(SER_STEPS - 1);
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q     <= a;
			b_q     <= b;
			mpl_q   <= mpl;
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (busy_q) begin
			acc_a_q <= {acc_a_q[30:0], 1'b0} + (mpl_q[15] ? {16'd0, a_q} : 32'd0);
			acc_b_q <= {acc_b_q[30:0], 1'b0} + (mpl_q[15] ? {16'd0, b_q} : 32'd0);
			mpl_q   <= {mpl_q[14:0], 1'b0};
		end
	end

	assign prod_a = acc_a_q;
	assign prod_b = acc_b_q;
	assign done   = done_q;

endmodule

`default_nettype wire

// File: src/rtoe_ser_div.sv
// ----------------------------------------------------------------------------
// rtoe_ser_div
// Bit-serial restoring divider, one quotient bit per cycle. The quotient is
// known to fit 16 bits, so the upper dividend half seeds the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoe_ser_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic      [15:0] quotient,
	output logic             done
);
	import rtoe_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [SER_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [15:0]          dsh_q;
	logic [15:0]          quo_q;
	logic [31:0]          dvs_q;

	logic [32:0] trial;
	logic [32:0] trial_sub;
	logic        fits;

	always_comb begin
		trial     = {rem_q, dsh_q[15]};
		trial_sub = trial - {1'b0, dvs_q};
		fits      = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= SER_CNT_W'(SER_STEPS - 1);
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {16'd0, dividend[31:16]};
			dsh_q <= dividend[15:0];
			quo_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[31:0] : trial[31:0];
			dsh_q <= {dsh_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: src/rtoe_rtt_unit.sv
// ----------------------------------------------------------------------------
// rtoe_rtt_unit
// Smoothed rtt and rtt variation update followed by the retransmission
// timeout calculation, with the wide adds and compares split across registered steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoe_rtt_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] rtt_sample,
	input  wire logic        [12:0] flush_interval,
	input  wire logic        [15:0] min_timeout,
	input  wire logic        [15:0] max_timeout,
	output logic signed      [31:0] srtt,
	output logic signed      [31:0] rttvar,
	output logic             [15:0] timeout,
	output rtoe_pkg::unit_stat_t    stat
);
	import rtoe_pkg::*;

	rtt_state_t state_q;
	rtt_state_t state_d;

	logic signed [31:0] srtt_q;
	logic signed [31:0] var_q;
	logic        [15:0] tmo_q;

	logic signed [31:0] r_q;
	logic signed [32:0] diff_q;
	logic signed [34:0] t7_q;
	logic        [32:0] absd_q;
	logic signed [33:0] v3_q;
	logic signed [35:0] s7r_q;
	logic signed [34:0] vsum_q;
	logic signed [33:0] mx_q;
	logic signed [34:0] rto_q;

	logic signed [31:0] seed_adj;
	logic signed [31:0] seed_var;
	logic signed [32:0] diff_w;
	logic signed [34:0] s_ext;
	logic signed [34:0] t7_w;
	logic        [32:0] absd_w;
	logic signed [33:0] var_ext;
	logic signed [33:0] v3_w;
	logic signed [35:0] s7r_w;
	logic signed [34:0] vsum_w;
	logic signed [35:0] s7r_adj;
	logic        [32:0] snew;
	logic signed [31:0] srtt_new;
	logic signed [34:0] vsum_adj;
	logic        [32:0] vq;
	logic signed [31:0] var_new;
	logic signed [33:0] var4_w;
	logic signed [33:0] fi_w;
	logic signed [34:0] rto_w;
	logic signed [34:0] min_w;
	logic signed [34:0] max_w;

	always_comb begin
		// truncating halve for the seed: bias negatives by one
		seed_adj = r_q + {31'd0, r_q[31]};
		seed_var = {seed_adj[31], seed_adj[31:1]};

		diff_w  = {r_q[31], r_q} - {srtt_q[31], srtt_q};
		s_ext   = {{3{srtt_q[31]}}, srtt_q};
		t7_w    = {s_ext[31:0], 3'b000} - s_ext;
		absd_w  = diff_q[32] ? (33'd0 - diff_q) : diff_q;
		var_ext = {{2{var_q[31]}}, var_q};
		v3_w    = {var_ext[32:0], 1'b0} + var_ext;
		s7r_w   = {t7_q[34], t7_q} + {{4{r_q[31]}}, r_q};
		vsum_w  = {v3_q[33], v3_q} + {2'b00, absd_q};

		// truncating divide by 8, then floor at 1
		s7r_adj  = s7r_q + {33'd0, {3{s7r_q[35]}}};
		snew     = s7r_adj[35:3];
		srtt_new = (snew[32] || (snew == '0)) ? 32'sd1 : snew[31:0];

		// truncating divide by 4, then saturate to 32 bits
		vsum_adj = vsum_q + {33'd0, {2{vsum_q[34]}}};
		vq       = vsum_adj[34:2];
		if (vq[32] != vq[31]) begin
			var_new = vq[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			var_new = vq[31:0];
		end

		var4_w = {var_q, 2'b00};
		fi_w   = {21'd0, flush_interval};
		rto_w  = {{3{srtt_q[31]}}, srtt_q} + {mx_q[33], mx_q};
		min_w  = {19'd0, min_timeout};
		max_w  = {19'd0, max_timeout};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			RT_IDLE:  if (start) state_d = RT_STEP1;
			RT_STEP1: state_d = (srtt_q == '0) ? RT_TMO1 : RT_STEP2;
			RT_STEP2: state_d = RT_STEP3;
			RT_STEP3: state_d = RT_STEP4;
			RT_STEP4: state_d = RT_TMO1;
			RT_TMO1:  state_d = RT_TMO2;
			RT_TMO2:  state_d = RT_TMO3;
			RT_TMO3:  state_d = RT_TMO4;
			RT_TMO4:  state_d = RT_DONE;
			RT_DONE:  state_d = RT_IDLE;
			default:  state_d = RT_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != RT_IDLE);
		stat.done = (state_q == RT_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RT_IDLE;
			srtt_q  <= '0;
			var_q   <= '0;
			tmo_q   <= TIMEOUT_RESET;
		end else begin
			state_q <= state_d;
			case (state_q)
				RT_STEP1: begin
					if (srtt_q == '0) begin
						srtt_q <= r_q;
						var_q  <= seed_var;
					end
				end
				RT_STEP3: srtt_q <= srtt_new;
				RT_STEP4: var_q <= var_new;
				RT_TMO4: begin
					tmo_q <= (rto_q > max_w) ? max_timeout : rto_q[15:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RT_IDLE: if (start) r_q <= rtt_sample;
			RT_STEP1: begin
				diff_q <= diff_w;
				t7_q   <= t7_w;
			end
			RT_STEP2: begin
				absd_q <= absd_w;
				v3_q   <= v3_w;
				s7r_q  <= s7r_w;
			end
			RT_STEP3: vsum_q <= vsum_w;
			RT_TMO1:  mx_q <= (var4_w > fi_w) ? var4_w : fi_w;
			RT_TMO2:  rto_q <= rto_w;
			RT_TMO3:  if (rto_q < min_w) rto_q <= min_w;
			default: ;
		endcase
	end

	assign srtt    = srtt_q;
	assign rttvar  = var_q;
	assign timeout = tmo_q;

	a_timeout_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == RT_DONE) && (min_timeout <= max_timeout)) |->
		((tmo_q >= min_timeout) && (tmo_q <= max_timeout)))
		else $error("timeout outside the configured bounds");

endmodule

`default_nettype wire

// File: src/rtoe_cwnd_unit.sv
// ----------------------------------------------------------------------------
// rtoe_cwnd_unit
// Congestion window growth while below the remote window: slow start below the
// threshold, otherwise additive increase via a bit-serial mss squared over increment quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoe_cwnd_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] remote_window,
	input  wire logic [15:0] segment_size,
	input  wire logic [15:0] slow_start_threshold,
	output logic      [15:0] cwnd,
	output rtoe_pkg::unit_stat_t stat
);
	import rtoe_pkg::*;

	cw_state_t state_q;
	cw_state_t state_d;

	logic [15:0] cwnd_q;
	logic [31:0] inc_q;
	logic [15:0] rmt_q;
	logic [31:0] incm_q;

	logic        avoid;
	logic [31:0] incm_w;
	logic [32:0] ss_sum;
	logic [15:0] quot_eff;
	logic [33:0] ca_sum;
	logic        mul_start;
	logic        div_start;
	logic [31:0] prod_a;
	logic [31:0] prod_b;
	logic        mul_done;
	logic [15:0] quot;
	logic        div_done;

	rtoe_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (segment_size),
		.b      (cwnd_q + 16'd1),
		.mpl    (segment_size),
		.prod_a (prod_a),
		.prod_b (prod_b),
		.done   (mul_done)
	);

	rtoe_ser_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_a),
		.divisor  (incm_q),
		.quotient (quot),
		.done     (div_done)
	);

	always_comb begin
		avoid    = (cwnd_q < rmt_q) && !(cwnd_q < slow_start_threshold);
		incm_w   = (inc_q < {16'd0, segment_size}) ? {16'd0, segment_size} : inc_q;
		ss_sum   = {1'b0, inc_q} + 33'(segment_size);
		// empty accumulator means no quotient term
		quot_eff = (incm_q == '0) ? 16'd0 : quot;
		ca_sum   = 34'(incm_q) + 34'(quot_eff) + 34'(segment_size >> MSS_SHIFT);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CW_IDLE:   if (start) state_d = CW_DECIDE;
			CW_DECIDE: state_d = avoid ? CW_MUL : CW_DONE;
			CW_MUL:    if (mul_done) state_d = CW_DIV;
			CW_DIV:    if (div_done) state_d = CW_SUM;
			CW_SUM:    state_d = CW_CMP;
			CW_CMP:    state_d = CW_DONE;
			CW_DONE:   state_d = CW_IDLE;
			default:   state_d = CW_IDLE;
		endcase
	end

	always_comb begin
		mul_start = (state_q == CW_DECIDE) && avoid;
		div_start = (state_q == CW_MUL) && mul_done;
		stat.busy = (state_q != CW_IDLE);
		stat.done = (state_q == CW_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CW_IDLE;
			cwnd_q  <= '0;
			inc_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				CW_DECIDE: begin
					if ((cwnd_q < rmt_q) && (cwnd_q < slow_start_threshold)) begin
						cwnd_q <= cwnd_q + 16'd1;
						inc_q  <= ss_sum[32] ? 32'hffff_ffff : ss_sum[31:0];
					end
				end
				CW_SUM: inc_q <= (ca_sum[33:32] != 2'b00) ? 32'hffff_ffff : ca_sum[31:0];
				CW_CMP: if (prod_b <= inc_q) cwnd_q <= cwnd_q + 16'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == CW_IDLE) && start) begin
			rmt_q <= remote_window;
		end
		if (state_q == CW_DECIDE) begin
			incm_q <= incm_w;
		end
	end

	assign cwnd = cwnd_q;

	// divisor is at least segment_size, so the quotient never exceeds it
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == CW_DIV) && div_done && (incm_q != '0)) |-> (quot <= segment_size))
		else $error("window quotient above segment size");

endmodule

`default_nettype wire

// File: src/rto_estimator_congestion_window.sv
// ----------------------------------------------------------------------------
// rto_estimator_congestion_window
// rtt sample: the first sample seeds srtt and skips the smoothing steps;
// window advance: congestion avoidance runs the bit-serial multiplier and
// then the divider; slow start and the no-growth case skip both units.
// One item at a time; the next item is taken the cycle after its result is
// loaded. Reset clears state to srtt 0, variation 0, timeout 200, window 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rto_estimator_congestion_window (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               action,
	input  wire logic signed [31:0] rtt_sample,
	input  wire logic        [15:0] remote_window,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic             [15:0] timeout_value,
	output logic signed      [31:0] smoothed_rtt,
	output logic signed      [31:0] rtt_variation,
	output logic             [15:0] congestion_window,
	input  wire logic               cfg_write,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [15:0] cfg_data
);
	import rtoe_pkg::*;

	top_state_t state_q;
	top_state_t state_d;

	logic [12:0] flush_interval_q;
	logic [15:0] min_timeout_q;
	logic [15:0] max_timeout_q;
	logic [15:0] segment_size_q;
	logic [15:0] ssthresh_q;

	logic        item_accept;
	logic        load;
	logic        result_valid_q;
	logic [15:0] timeout_q;
	logic [31:0] srtt_q;
	logic [31:0] rttvar_q;
	logic [15:0] cwnd_q;

	logic signed [31:0] srtt_w;
	logic signed [31:0] rttvar_w;
	logic        [15:0] timeout_w;
	logic        [15:0] cwnd_w;
	unit_stat_t         rtt_stat;
	unit_stat_t         cw_stat;

	rtoe_rtt_unit u_rtt (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (item_accept && !action),
		.rtt_sample     (rtt_sample),
		.flush_interval (flush_interval_q),
		.min_timeout    (min_timeout_q),
		.max_timeout    (max_timeout_q),
		.srtt           (srtt_w),
		.rttvar         (rttvar_w),
		.timeout        (timeout_w),
		.stat           (rtt_stat)
	);

	rtoe_cwnd_unit u_cwnd (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (item_accept && action),
		.remote_window        (remote_window),
		.segment_size         (segment_size_q),
		.slow_start_threshold (ssthresh_q),
		.cwnd                 (cwnd_w),
		.stat                 (cw_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_interval_q <= FLUSH_INTERVAL_RESET;
			min_timeout_q    <= MIN_TIMEOUT_RESET;
			max_timeout_q    <= MAX_TIMEOUT_RESET;
			segment_size_q   <= SEGMENT_SIZE_RESET;
			ssthresh_q       <= SLOW_START_THRESHOLD_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FLUSH_INTERVAL:       flush_interval_q <= cfg_data[12:0];
				REG_MIN_TIMEOUT:          min_timeout_q    <= cfg_data;
				REG_MAX_TIMEOUT:          max_timeout_q    <= cfg_data;
				REG_SEGMENT_SIZE:         segment_size_q   <= cfg_data;
				REG_SLOW_START_THRESHOLD: ssthresh_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			TOP_IDLE: if (item_accept) state_d = TOP_RUN;
			TOP_RUN:  if (rtt_stat.done || cw_stat.done) state_d = TOP_PUSH;
			TOP_PUSH: if (load) state_d = TOP_IDLE;
			default:  state_d = TOP_IDLE;
		endcase
	end

	always_comb begin
		item_stall  = (state_q != TOP_IDLE);
		item_accept = item_valid && (state_q == TOP_IDLE);
		// output register takes the result once its previous transfer is done
		load        = (state_q == TOP_PUSH) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= TOP_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			timeout_q <= timeout_w;
			srtt_q    <= srtt_w;
			rttvar_q  <= rttvar_w;
			cwnd_q    <= cwnd_w;
		end
	end

	assign result_valid      = result_valid_q;
	assign timeout_value     = timeout_q;
	assign smoothed_rtt      = srtt_q;
	assign rtt_variation     = rttvar_q;
	assign congestion_window = cwnd_q;

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(rtt_stat.busy && cw_stat.busy))
		else $error("both update units busy");

	a_stall_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input open while an item is in flight");

	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == TOP_PUSH))
		else $error("result raised without a finished item");

endmodule

`default_nettype wire
